>>> sv/phs_pkg.sv
// phs_pkg: shared widths, register indexes and pipeline payload types
// used by the pixel_hsv_shift top level and its port checker
`default_nettype none
package phs_pkg;
  localparam int ChanW  = 8;
  localparam int ShiftW = 9;
  localparam int CfgIdxW = 2;
  localparam int DivSteps = 8;
  localparam int FracW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HUE   = 2'd0,
    CFG_SAT   = 2'd1,
    CFG_VAL   = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic [ChanW-1:0] a;
  } pix_t;

  // state of both dividers while they run one bit per stage
  typedef struct packed {
    logic [ChanW-1:0] rem_s;
    logic [ChanW-1:0] low_s;
    logic [ChanW-1:0] q_s;
    logic [11:0]      rem_h;
    logic [11:0]      dv_h;
    logic [ChanW-1:0] q_h;
    logic [ChanW-1:0] mx;
    logic             grey;
    pix_t             pix;
  } div_t;
endpackage
`default_nettype wire

>>> sv/pixel_hsv_shift.sv
// pixel_hsv_shift: rgba pixel hue/saturation/value adjust, 15-stage pipeline
// depends on phs_pkg; checked by phs_port_checker
//
// channel | direction | handshake         | payload
// in      | request   | in_valid/in_stall  | in_red/green/blue/alpha
// out     | result    | out_valid/out_stall| out_red/green/blue/alpha
// cfg     | write     | cfg_valid/ready    | cfg_index, cfg_data
//
// one pixel per cycle while out_stall_i does not hold the pipeline
// most of the pipeline is the two 8-step restoring dividers, one bit per stage
// the whole pipeline holds while a result waits under out_stall_i
// reset clears valid bits and all three offsets to zero
`default_nettype none
module pixel_hsv_shift
  import phs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ChanW-1:0]    in_red_i,
  input  wire logic [ChanW-1:0]    in_green_i,
  input  wire logic [ChanW-1:0]    in_blue_i,
  input  wire logic [ChanW-1:0]    in_alpha_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ChanW-1:0]         out_red_o,
  output logic [ChanW-1:0]         out_green_o,
  output logic [ChanW-1:0]         out_blue_o,
  output logic [ChanW-1:0]         out_alpha_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ShiftW-1:0]   cfg_data_i
);

  logic en;
  logic signed [ShiftW-1:0] hue_q, sat_q, val_q;

  logic out_valid_q;
  pix_t out_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= '0;
      sat_q <= '0;
      val_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HUE: hue_q <= cfg_data_i;
        CFG_SAT: sat_q <= cfg_data_i;
        CFG_VAL: val_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic in_vld_q;
  pix_t in_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (en) in_vld_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) in_q <= '{r: in_red_i, g: in_green_i, b: in_blue_i, a: in_alpha_i};
  end

  // max, min, sector position and divider setup
  logic [ChanW-1:0] mx, mn, dd;
  logic signed [12:0] pos;
  logic [11:0] d6;
  div_t div_d;
  always_comb begin
    mx = in_q.r;
    mn = in_q.r;
    if (in_q.g > mx) mx = in_q.g;
    if (in_q.b > mx) mx = in_q.b;
    if (in_q.g < mn) mn = in_q.g;
    if (in_q.b < mn) mn = in_q.b;
    dd = mx - mn;
    d6 = {4'd0, dd} * 12'd6;
    priority if (in_q.r == mx) begin
      pos = $signed({5'd0, in_q.g}) - $signed({5'd0, in_q.b});
    end else if (in_q.g == mx) begin
      pos = $signed({4'd0, dd, 1'b0}) + $signed({5'd0, in_q.b}) - $signed({5'd0, in_q.r});
    end else begin
      pos = $signed({3'd0, dd, 2'b0}) + $signed({5'd0, in_q.r}) - $signed({5'd0, in_q.g});
    end
    if (pos < 0) pos = pos + $signed({1'b0, d6});
    div_d.rem_s = 8'(({8'd0, dd} * 16'd255) >> 8);
    div_d.low_s = 8'({8'd0, dd} * 16'd255);
    div_d.q_s   = '0;
    div_d.rem_h = pos[11:0];
    div_d.dv_h  = d6;
    div_d.q_h   = '0;
    div_d.mx    = mx;
    div_d.grey  = (dd == '0);
    div_d.pix   = in_q;
  end

  function automatic div_t div_step(input div_t x);
    div_t y;
    logic [ChanW:0] ts;
    logic [11:0] th;
    y  = x;
    ts = {x.rem_s, x.low_s[ChanW-1]};
    th = {x.rem_h[10:0], 1'b0};
    y.low_s = {x.low_s[ChanW-2:0], 1'b0};
    if (ts >= {1'b0, x.mx}) begin
      y.rem_s = 8'(ts - {1'b0, x.mx});
      y.q_s   = {x.q_s[ChanW-2:0], 1'b1};
    end else begin
      y.rem_s = ts[ChanW-1:0];
      y.q_s   = {x.q_s[ChanW-2:0], 1'b0};
    end
    if (th >= x.dv_h) begin
      y.rem_h = th - x.dv_h;
      y.q_h   = {x.q_h[ChanW-2:0], 1'b1};
    end else begin
      y.rem_h = th;
      y.q_h   = {x.q_h[ChanW-2:0], 1'b0};
    end
    return y;
  endfunction

  div_t div_q [DivSteps+1];
  logic [DivSteps:0] div_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_vld_q <= '0;
    else if (en) div_vld_q <= {div_vld_q[DivSteps-1:0], in_vld_q};
  end
  always_ff @(posedge clk_i) begin
    if (en) div_q[0] <= div_d;
  end
  for (genvar i = 1; i <= DivSteps; i++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) div_q[i] <= div_step(div_q[i-1]);
    end
  end

  // apply offsets
  div_t dl;
  logic [ChanW-1:0] h_d, s_d, v_d;
  logic signed [ShiftW+1:0] ssum, vsum;
  logic [ChanW-1:0] h0, s0;
  assign dl = div_q[DivSteps];
  always_comb begin
    h0   = dl.grey ? '0 : dl.q_h;
    s0   = dl.grey ? '0 : dl.q_s;
    h_d  = h0 + hue_q[ChanW-1:0];
    ssum = $signed({3'd0, s0}) + (ShiftW+2)'(sat_q);
    vsum = $signed({3'd0, dl.mx}) + (ShiftW+2)'(val_q);
    if (ssum < 0) s_d = '0;
    else if (ssum > 255) s_d = 8'd255;
    else s_d = ssum[ChanW-1:0];
    if (vsum < 0) v_d = '0;
    else if (vsum > 255) v_d = 8'd255;
    else v_d = vsum[ChanW-1:0];
  end

  logic hsv_vld_q;
  logic [ChanW-1:0] h_q, s_q, v_q;
  pix_t hsv_pix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hsv_vld_q <= 1'b0;
    else if (en) hsv_vld_q <= div_vld_q[DivSteps];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q <= h_d;
      s_q <= s_d;
      v_q <= v_d;
      hsv_pix_q <= dl.pix;
    end
  end

  // sector position and chroma product
  logic [18:0] p_d;
  assign p_d = {1'b0, h_q, 10'd0} + {2'b0, h_q, 9'd0};
  logic r1_vld_q;
  logic [2:0] k1_q;
  logic [FracW-1:0] f1_q;
  logic [15:0] prod_q;
  logic [ChanW-1:0] v1_q;
  pix_t r1_pix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r1_vld_q <= 1'b0;
    else if (en) r1_vld_q <= hsv_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_q     <= p_d[18:16];
      f1_q     <= p_d[FracW-1:0];
      prod_q   <= {8'd0, v_q} * {8'd0, s_q};
      v1_q     <= v_q;
      r1_pix_q <= hsv_pix_q;
    end
  end

  // divide by 255, offset and ramp weight
  logic [16:0] y1, y2;
  logic [ChanW-1:0] c_d;
  assign y1  = {1'b0, prod_q} + 17'd1;
  assign y2  = y1 + {8'd0, y1[16:8]};
  assign c_d = y2[15:8];

  logic r2_vld_q;
  logic [2:0] k2_q;
  logic [ChanW-1:0] c2_q, m2_q;
  logic [FracW:0] w2_q;
  pix_t r2_pix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r2_vld_q <= 1'b0;
    else if (en) r2_vld_q <= r1_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      k2_q <= k1_q;
      c2_q <= c_d;
      m2_q <= v1_q - c_d;
      w2_q <= k1_q[0] ? (17'h10000 - {1'b0, f1_q}) : {1'b0, f1_q};
      r2_pix_q <= r1_pix_q;
    end
  end

  // ramp
  logic [24:0] cw;
  assign cw = {17'd0, c2_q} * {8'd0, w2_q};
  logic r3_vld_q;
  logic [2:0] k3_q;
  logic [ChanW-1:0] c3_q, m3_q, x3_q;
  pix_t r3_pix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r3_vld_q <= 1'b0;
    else if (en) r3_vld_q <= r2_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      k3_q <= k2_q;
      c3_q <= c2_q;
      m3_q <= m2_q;
      x3_q <= cw[23:16];
      r3_pix_q <= r2_pix_q;
    end
  end

  // sector select and output register
  pix_t out_d;
  logic [ChanW-1:0] rr, gg, bb;
  always_comb begin
    rr = '0;
    gg = '0;
    bb = '0;
    unique case (k3_q)
      3'd0: begin rr = c3_q; gg = x3_q; end
      3'd1: begin rr = x3_q; gg = c3_q; end
      3'd2: begin gg = c3_q; bb = x3_q; end
      3'd3: begin gg = x3_q; bb = c3_q; end
      3'd4: begin rr = x3_q; bb = c3_q; end
      default: begin rr = c3_q; bb = x3_q; end
    endcase
    out_d = r3_pix_q;
    if (r3_pix_q.a != '0) begin
      out_d.r = rr + m3_q;
      out_d.g = gg + m3_q;
      out_d.b = bb + m3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= r3_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q.r;
  assign out_green_o = out_q.g;
  assign out_blue_o  = out_q.b;
  assign out_alpha_o = out_q.a;

endmodule
`default_nettype wire

>>> sv/phs_port_checker.sv
// phs_port_checker: port-level assertions for pixel_hsv_shift
// depends on phs_pkg; bound to the top level below
`default_nettype none
module phs_port_checker
  import phs_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [ChanW-1:0] out_red_o,
  input wire logic [ChanW-1:0] out_alpha_o,
  input wire logic             cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_red_o) && $stable(out_alpha_o))
    else $error("stalled result changed");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while pipeline held");

  a_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("stall without waiting result");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind pixel_hsv_shift phs_port_checker u_phs_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_red_o   (out_red_o),
  .out_alpha_o (out_alpha_o),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire
